FILE: design/contiguous_work_partitioner_assert.svh
// Assertion macros shared by the partitioner RTL.
`ifndef CONTIGUOUS_WORK_PARTITIONER_ASSERT_SVH
`define CONTIGUOUS_WORK_PARTITIONER_ASSERT_SVH

// Same-cycle implication, checked on every clock edge outside reset.
`define CWP_ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("cwp assertion failed");

// Next-cycle implication, checked on every clock edge outside reset.
`define CWP_ASSERT_NXT(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("cwp assertion failed");

`endif

FILE: design/cwp_pkg.sv
// Shared types and constants of the contiguous work partitioner.
package cwp_pkg;

    localparam int DEF_MAX_CORES = 32;
    localparam int DEF_MAX_ITEMS = 4096;

    localparam int WEIGHT_W   = 24;
    localparam int CORES_W    = 6;
    localparam int ITEMS_W    = 13;
    localparam int SLOT_W     = 5;
    localparam int LOAD_OUT_W = 36;
    localparam int LOAD_W     = 37;
    localparam int VAL_W      = 39;
    localparam int CFG_W      = 13;
    localparam int CFG_ADDR_W = 2;
    localparam int S_TDATA_W  = 24;
    localparam int M_TDATA_W  = 56;
    localparam int PASS_LIMIT = 131072;
    localparam int PASS_W     = 18;

    typedef enum logic [CFG_ADDR_W-1:0] {
        REG_CORES = 2'd0,
        REG_ITEMS = 2'd1,
        REG_SHARE = 2'd2
    } cfg_reg_t;

    typedef struct packed {
        logic busy;
        logic done;
    } div_stat_t;

endpackage

FILE: design/cwp_wmem.sv
// Weight store with one write port and a registered read port.
module cwp_wmem #(
    parameter int DEPTH = cwp_pkg::DEF_MAX_ITEMS,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic                          aclk,
    input  logic                          wr_en,
    input  logic [AW-1:0]                 wr_addr,
    input  logic [cwp_pkg::WEIGHT_W-1:0]  wr_data,
    input  logic [AW-1:0]                 rd_addr,
    output logic [cwp_pkg::WEIGHT_W-1:0]  rd_data
);
    import cwp_pkg::*;

    logic [WEIGHT_W-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule

FILE: design/cwp_div.sv
// Restoring divider that produces one quotient bit per cycle.
module cwp_div #(
    parameter int DVW = 6
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          start,
    input  logic [cwp_pkg::VAL_W-1:0]     dividend,
    input  logic [DVW-1:0]                divisor,
    output logic [cwp_pkg::VAL_W-1:0]     quotient,
    output cwp_pkg::div_stat_t            stat
);
    import cwp_pkg::*;

    localparam int CNT_W = $clog2(VAL_W + 1);

    logic [VAL_W-1:0] quo_reg;
    logic [DVW-1:0]   rem_reg;
    logic [DVW-1:0]   dvs_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic             busy_reg;
    logic             done_reg;
    logic [DVW:0]     shifted;
    logic             fits;

    assign shifted = {rem_reg, quo_reg[VAL_W-1]};
    assign fits    = shifted >= {1'b0, dvs_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= CNT_W'(VAL_W);
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == CNT_W'(1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            quo_reg <= dividend;
            rem_reg <= '0;
            dvs_reg <= divisor;
        end else if (busy_reg) begin
            quo_reg <= {quo_reg[VAL_W-2:0], fits};
            rem_reg <= fits ? DVW'(shifted - {1'b0, dvs_reg}) : DVW'(shifted);
        end
    end

    assign quotient  = quo_reg;
    assign stat.busy = busy_reg;
    assign stat.done = done_reg;

endmodule

FILE: design/contiguous_work_partitioner.sv
// Top level of the contiguous work partitioner: loader, sequencer and report stage.
`include "contiguous_work_partitioner_assert.svh"

// Weights stream in at one transfer per cycle and are written into the store's write port.
// The transfer with tlast set starts partitioning, and the input stays stalled until all
// MAX_CORES core reports have been taken. Partitioning is a sequencer around accumulator
// registers and the store's one read port: each weight summed takes a read state and an
// accumulate state. The even split, the total, the greedy split and the tuned split are
// summed in turn, each core cut adds a serial ceiling divide, and every refinement pass
// walks the cores forward and backward, with a pass over the loads for the maximum after
// each walk. The report then sends one transfer per core slot.
module contiguous_work_partitioner #(
    parameter int MAX_CORES = cwp_pkg::DEF_MAX_CORES,
    parameter int MAX_ITEMS = cwp_pkg::DEF_MAX_ITEMS
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    // s_tdata: weight[23:0]
    input  logic [cwp_pkg::S_TDATA_W-1:0]   s_tdata,
    input  logic                            s_tvalid,
    input  logic                            s_tlast,
    output logic                            s_tready,
    // m_tdata: core_slot[4:0], start_index[17:5], run_load[53:18], zero fill[55:54]
    output logic [cwp_pkg::M_TDATA_W-1:0]   m_tdata,
    output logic                            m_tvalid,
    output logic                            m_tlast,
    input  logic                            m_tready,
    input  logic                            cfg_we,
    input  logic [cwp_pkg::CFG_ADDR_W-1:0]  cfg_addr,
    input  logic [cwp_pkg::CFG_W-1:0]       cfg_wdata
);
    import cwp_pkg::*;

    localparam int IW = $clog2(MAX_ITEMS + 1);
    localparam int AW = (MAX_ITEMS > 1) ? $clog2(MAX_ITEMS) : 1;
    localparam int CW = $clog2(MAX_CORES + 1);
    localparam int CI = (MAX_CORES > 1) ? $clog2(MAX_CORES) : 1;
    localparam int PW = ITEMS_W + CW;

    typedef enum logic [26:0] {
        S_LOAD    = 27'd1 << 0,
        S_EVEN    = 27'd1 << 1,
        S_LR_S    = 27'd1 << 2,
        S_LR_E    = 27'd1 << 3,
        S_LR_RD   = 27'd1 << 4,
        S_LR_AC   = 27'd1 << 5,
        S_SUM_RD  = 27'd1 << 6,
        S_SUM_AC  = 27'd1 << 7,
        S_DIVW    = 27'd1 << 8,
        S_G_START = 27'd1 << 9,
        S_G_RD    = 27'd1 << 10,
        S_G_AC    = 27'd1 << 11,
        S_G_CHK   = 27'd1 << 12,
        S_G_SUB   = 27'd1 << 13,
        S_G_DS    = 27'd1 << 14,
        S_MX      = 27'd1 << 15,
        S_FW_S    = 27'd1 << 16,
        S_FW_RD   = 27'd1 << 17,
        S_FW_A    = 27'd1 << 18,
        S_FW_B    = 27'd1 << 19,
        S_BW_S    = 27'd1 << 20,
        S_BW_T    = 27'd1 << 21,
        S_BW_A    = 27'd1 << 22,
        S_BW_A2   = 27'd1 << 23,
        S_BW_B    = 27'd1 << 24,
        S_BW_B2   = 27'd1 << 25,
        S_OUT     = 27'd1 << 26
    } state_t;

    typedef enum logic [2:0] {
        RET_TOP,
        RET_MID,
        RET_END,
        RET_EVEN,
        RET_TUNED
    } mx_ret_t;

    typedef logic signed [VAL_W-1:0]  val_t;
    typedef logic signed [LOAD_W-1:0] load_t;

    state_t  state_reg;
    mx_ret_t mret_reg;

    logic [CORES_W-1:0] cores_reg;
    logic [ITEMS_W-1:0] items_reg;
    logic [ITEMS_W-1:0] share_reg;
    logic [IW-1:0]      fill_reg;

    logic [CW-1:0] n_reg;
    logic [IW-1:0] tot_reg;
    logic [CW-1:0] c_reg;
    logic [IW-1:0] i_reg;
    logic [IW-1:0] s_reg;
    logic [IW-1:0] e_reg;
    logic [IW-1:0] start_reg;
    logic [PW-1:0] prod_reg;
    logic [PASS_W-1:0] pass_reg;
    logic sel_reg;
    logic brk_reg;
    logic pick_reg;
    logic wok_reg;

    val_t acc_reg, sum_reg, avg_reg, single_reg, lastw_reg, w_reg, a_reg;
    val_t top_reg, mid_reg, mx_reg, emax_reg;

    logic [IW-1:0] es_reg [MAX_CORES];
    logic [IW-1:0] ts_reg [MAX_CORES];
    load_t         el_reg [MAX_CORES];
    load_t         tl_reg [MAX_CORES];

    logic [CI-1:0] ci, cm1, cp1;
    logic [CW-1:0] c_inc;
    logic          c_last;
    logic [CW-1:0] n_clamp;
    logic [IW-1:0] tot_clamp;

    logic [IW-1:0]       rd_addr;
    logic                rd_ok;
    logic [WEIGHT_W-1:0] rd_data;
    val_t                wt;

    logic               div_start;
    logic [VAL_W-1:0]   div_dividend;
    logic [CW-1:0]      div_k;
    logic [VAL_W-1:0]   div_q;
    div_stat_t          div_stat;

    val_t          mx_val, mx_new, redo;
    logic [IW-1:0] st_sel_c, st_sel_cp1;

    assign ci     = c_reg[CI-1:0];
    assign cm1    = CI'(c_reg - 1'b1);
    assign cp1    = CI'(c_reg + 1'b1);
    assign c_inc  = c_reg + 1'b1;
    assign c_last = (c_reg == n_reg - 1'b1);

    assign n_clamp   = (cores_reg == '0) ? CW'(1) :
                       (int'(cores_reg) > MAX_CORES) ? CW'(MAX_CORES) : CW'(cores_reg);
    assign tot_clamp = (int'(items_reg) > MAX_ITEMS) ? IW'(MAX_ITEMS) : IW'(items_reg);

    assign wt = wok_reg ? val_t'(VAL_W'(rd_data)) : '0;

    assign st_sel_c   = sel_reg ? ts_reg[ci] : es_reg[ci];
    assign st_sel_cp1 = sel_reg ? ts_reg[cp1] : es_reg[cp1];
    assign mx_val     = sel_reg ? val_t'(tl_reg[ci]) : val_t'(el_reg[ci]);
    assign mx_new     = (c_reg == '0 || mx_val > mx_reg) ? mx_val : mx_reg;
    assign redo       = single_reg - lastw_reg;

    // Read port of the weight store; an address outside the row reads as zero.
    always_comb begin
        rd_addr = '0;
        rd_ok   = 1'b0;
        unique case (state_reg)
            S_LR_RD, S_SUM_RD, S_G_RD: begin
                rd_addr = i_reg;
                rd_ok   = i_reg < tot_reg;
            end
            S_FW_RD: begin
                rd_addr = s_reg;
                rd_ok   = s_reg < tot_reg;
            end
            S_BW_T: begin
                rd_addr = s_reg - 1'b1;
                rd_ok   = (s_reg != '0) && (s_reg - 1'b1 < tot_reg);
            end
            default: begin
                rd_addr = '0;
                rd_ok   = 1'b0;
            end
        endcase
    end

    assign div_start    = (state_reg == S_SUM_RD && i_reg >= tot_reg) || (state_reg == S_G_DS);
    assign div_k        = (state_reg == S_G_DS) ? CW'(n_reg - c_reg) : n_reg;
    assign div_dividend = $unsigned(sum_reg) + VAL_W'(div_k) - VAL_W'(1);

    cwp_wmem #(
        .DEPTH (MAX_ITEMS),
        .AW    (AW)
    ) u_wmem (
        .aclk    (aclk),
        .wr_en   (s_tvalid && s_tready && (int'(fill_reg) < MAX_ITEMS)),
        .wr_addr (fill_reg[AW-1:0]),
        .wr_data (s_tdata[WEIGHT_W-1:0]),
        .rd_addr (rd_addr[AW-1:0]),
        .rd_data (rd_data)
    );

    cwp_div #(
        .DVW (CW)
    ) u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (div_k),
        .quotient (div_q),
        .stat     (div_stat)
    );

    // Configuration registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cores_reg <= CORES_W'(1);
            items_reg <= ITEMS_W'(1);
            share_reg <= ITEMS_W'(1);
        end else if (cfg_we) begin
            unique case (cfg_reg_t'(cfg_addr))
                REG_CORES: cores_reg <= cfg_wdata[CORES_W-1:0];
                REG_ITEMS: items_reg <= cfg_wdata[ITEMS_W-1:0];
                REG_SHARE: share_reg <= cfg_wdata[ITEMS_W-1:0];
                default: ;
            endcase
        end
    end

    // Control state.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_LOAD;
            fill_reg  <= '0;
            c_reg     <= '0;
            wok_reg   <= 1'b0;
        end else begin
            wok_reg <= rd_ok;
            unique case (state_reg)
                S_LOAD: begin
                    if (s_tvalid) begin
                        if (s_tlast) begin
                            fill_reg  <= '0;
                            c_reg     <= '0;
                            state_reg <= S_EVEN;
                        end else if (int'(fill_reg) < MAX_ITEMS) begin
                            fill_reg <= fill_reg + 1'b1;
                        end
                    end
                end
                S_EVEN: begin
                    if (c_last) begin
                        c_reg     <= '0;
                        state_reg <= S_LR_S;
                    end else begin
                        c_reg <= c_inc;
                    end
                end
                S_LR_S: state_reg <= S_LR_E;
                S_LR_E, S_LR_RD: begin
                    if (state_reg == S_LR_E && !(brk_reg || s_reg >= tot_reg)) begin
                        state_reg <= S_LR_RD;
                    end else if (state_reg == S_LR_RD && i_reg < e_reg) begin
                        state_reg <= S_LR_AC;
                    end else if (!c_last) begin
                        c_reg     <= c_inc;
                        state_reg <= S_LR_S;
                    end else begin
                        c_reg     <= '0;
                        state_reg <= sel_reg ? S_MX : S_SUM_RD;
                    end
                end
                S_LR_AC:  state_reg <= S_LR_RD;
                S_SUM_RD: begin
                    if (i_reg < tot_reg) begin
                        state_reg <= S_SUM_AC;
                    end else begin
                        c_reg     <= '0;
                        state_reg <= S_DIVW;
                    end
                end
                S_SUM_AC: state_reg <= S_SUM_RD;
                S_DIVW: begin
                    if (div_stat.done) begin
                        if (c_inc < n_reg) begin
                            c_reg     <= c_inc;
                            state_reg <= S_G_START;
                        end else begin
                            c_reg     <= '0;
                            state_reg <= S_LR_S;
                        end
                    end
                end
                S_G_START: state_reg <= S_G_RD;
                S_G_RD: begin
                    state_reg <= (single_reg < avg_reg && i_reg < tot_reg) ? S_G_AC : S_G_CHK;
                end
                S_G_AC: state_reg <= S_G_RD;
                S_G_CHK: begin
                    if ({1'b0, start_reg} + 1'b1 < {1'b0, i_reg}) begin
                        state_reg <= S_G_SUB;
                    end else if (c_inc < n_reg) begin
                        c_reg     <= c_inc;
                        state_reg <= S_G_START;
                    end else begin
                        c_reg     <= '0;
                        state_reg <= S_LR_S;
                    end
                end
                S_G_SUB: state_reg <= S_G_DS;
                S_G_DS:  state_reg <= S_DIVW;
                S_MX: begin
                    if (!c_last) begin
                        c_reg <= c_inc;
                    end else begin
                        c_reg <= '0;
                        case (mret_reg)
                            RET_TOP: begin
                                c_reg     <= CW'(1);
                                state_reg <= S_FW_S;
                            end
                            RET_MID: begin
                                c_reg     <= n_reg - 1'b1;
                                state_reg <= S_BW_S;
                            end
                            RET_END: begin
                                if (mx_new < top_reg && (int'(pass_reg) + 1 < PASS_LIMIT)) begin
                                    c_reg     <= CW'(1);
                                    state_reg <= S_FW_S;
                                end
                            end
                            RET_TUNED: state_reg <= S_OUT;
                            default: ;
                        endcase
                    end
                end
                S_FW_S: begin
                    if (c_reg >= n_reg) begin
                        c_reg     <= '0;
                        state_reg <= S_MX;
                    end else begin
                        state_reg <= S_FW_RD;
                    end
                end
                S_FW_RD: begin
                    if (s_reg == tot_reg) begin
                        c_reg     <= '0;
                        state_reg <= S_MX;
                    end else if (s_reg < tot_reg && s_reg != '0) begin
                        state_reg <= S_FW_A;
                    end else begin
                        c_reg     <= c_inc;
                        state_reg <= S_FW_S;
                    end
                end
                S_FW_A: begin
                    if (a_reg + wt < top_reg) begin
                        state_reg <= S_FW_B;
                    end else begin
                        c_reg     <= c_inc;
                        state_reg <= S_FW_S;
                    end
                end
                S_FW_B: begin
                    c_reg     <= c_inc;
                    state_reg <= S_FW_S;
                end
                S_BW_S: begin
                    if (c_reg == '0) begin
                        state_reg <= S_MX;
                    end else begin
                        state_reg <= S_BW_T;
                    end
                end
                S_BW_T: begin
                    if (s_reg == tot_reg) begin
                        if (ts_reg[cm1] == tot_reg) begin
                            c_reg     <= c_reg - 1'b1;
                            state_reg <= S_BW_S;
                        end else begin
                            state_reg <= S_BW_A;
                        end
                    end else if (s_reg != '0) begin
                        state_reg <= S_BW_B;
                    end else begin
                        c_reg     <= '0;
                        state_reg <= S_MX;
                    end
                end
                S_BW_A: state_reg <= S_BW_A2;
                S_BW_B: begin
                    if (val_t'(tl_reg[ci]) + wt >= mid_reg) begin
                        c_reg     <= c_reg - 1'b1;
                        state_reg <= S_BW_S;
                    end else begin
                        state_reg <= S_BW_B2;
                    end
                end
                S_BW_A2, S_BW_B2: begin
                    c_reg     <= c_reg - 1'b1;
                    state_reg <= S_BW_S;
                end
                S_OUT: begin
                    if (m_tready) begin
                        if (int'(c_reg) == MAX_CORES - 1) begin
                            c_reg     <= '0;
                            state_reg <= S_LOAD;
                        end else begin
                            c_reg <= c_inc;
                        end
                    end
                end
                default: state_reg <= S_LOAD;
            endcase
        end
    end

    // Datapath registers and the split tables.
    always_ff @(posedge aclk) begin
        case (state_reg)
            S_LOAD: begin
                n_reg    <= n_clamp;
                tot_reg  <= tot_clamp;
                prod_reg <= '0;
            end
            S_EVEN: begin
                es_reg[ci] <= (prod_reg < PW'(tot_reg)) ? IW'(prod_reg) : tot_reg;
                prod_reg   <= prod_reg + PW'(share_reg);
                sel_reg    <= 1'b0;
                brk_reg    <= 1'b0;
            end
            S_LR_S: s_reg <= st_sel_c;
            S_LR_E: begin
                e_reg   <= (c_inc < n_reg) ? st_sel_cp1 : tot_reg;
                acc_reg <= '0;
                if (brk_reg || s_reg >= tot_reg) begin
                    brk_reg <= 1'b1;
                    if (sel_reg) tl_reg[ci] <= '0;
                    else el_reg[ci] <= '0;
                    // An empty last run ends the pass here, so the next phase starts clean.
                    if (c_last) begin
                        i_reg    <= '0;
                        sum_reg  <= '0;
                        pass_reg <= '0;
                        mret_reg <= RET_TOP;
                    end
                end else begin
                    i_reg <= s_reg;
                end
            end
            S_LR_RD: begin
                if (!(i_reg < e_reg)) begin
                    if (sel_reg) tl_reg[ci] <= LOAD_W'(acc_reg);
                    else el_reg[ci] <= LOAD_W'(acc_reg);
                    if (c_last) begin
                        i_reg    <= '0;
                        sum_reg  <= '0;
                        pass_reg <= '0;
                        mret_reg <= RET_TOP;
                    end
                end
            end
            S_LR_AC: begin
                acc_reg <= acc_reg + wt;
                i_reg   <= i_reg + 1'b1;
            end
            S_SUM_RD: begin
                if (!(i_reg < tot_reg)) ts_reg[0] <= '0;
            end
            S_SUM_AC: begin
                sum_reg <= sum_reg + wt;
                i_reg   <= i_reg + 1'b1;
            end
            S_DIVW: begin
                if (div_stat.done) begin
                    avg_reg <= val_t'(div_q);
                    sel_reg <= 1'b1;
                    brk_reg <= 1'b0;
                end
            end
            S_G_START: begin
                start_reg  <= ts_reg[cm1];
                i_reg      <= ts_reg[cm1];
                single_reg <= '0;
                sel_reg    <= 1'b1;
                brk_reg    <= 1'b0;
            end
            S_G_AC: begin
                single_reg <= single_reg + wt;
                lastw_reg  <= wt;
                i_reg      <= i_reg + 1'b1;
            end
            S_G_CHK: begin
                if ({1'b0, start_reg} + 1'b1 < {1'b0, i_reg}
                        && (single_reg - avg_reg > avg_reg - redo)) begin
                    ts_reg[ci] <= i_reg - 1'b1;
                    single_reg <= redo;
                end else begin
                    ts_reg[ci] <= i_reg;
                end
            end
            S_G_SUB: sum_reg <= sum_reg - single_reg;
            S_MX: begin
                mx_reg <= mx_new;
                if (c_last) begin
                    case (mret_reg)
                        RET_TOP: top_reg <= mx_new;
                        RET_MID: begin
                            mid_reg  <= mx_new;
                            mret_reg <= RET_END;
                        end
                        RET_END: begin
                            if (mx_new < top_reg && (int'(pass_reg) + 1 < PASS_LIMIT)) begin
                                top_reg  <= mx_new;
                                pass_reg <= pass_reg + 1'b1;
                                mret_reg <= RET_MID;
                            end else begin
                                sel_reg  <= 1'b0;
                                mret_reg <= RET_EVEN;
                            end
                        end
                        RET_EVEN: begin
                            emax_reg <= mx_new;
                            sel_reg  <= 1'b1;
                            mret_reg <= RET_TUNED;
                        end
                        RET_TUNED: pick_reg <= emax_reg > mx_new;
                        default: ;
                    endcase
                    if (mret_reg == RET_TOP) mret_reg <= RET_MID;
                end
            end
            S_FW_S: s_reg <= ts_reg[ci];
            S_FW_RD: a_reg <= val_t'(tl_reg[cm1]);
            S_FW_A: begin
                w_reg <= wt;
                if (a_reg + wt < top_reg) tl_reg[cm1] <= LOAD_W'(a_reg + wt);
            end
            S_FW_B: begin
                tl_reg[ci] <= LOAD_W'(val_t'(tl_reg[ci]) - w_reg);
                ts_reg[ci] <= s_reg + 1'b1;
            end
            S_BW_S: s_reg <= ts_reg[ci];
            S_BW_A: begin
                tl_reg[cm1] <= LOAD_W'(val_t'(tl_reg[cm1]) - wt);
                w_reg       <= wt;
            end
            S_BW_A2: begin
                tl_reg[ci] <= LOAD_W'(w_reg);
                ts_reg[ci] <= s_reg - 1'b1;
            end
            S_BW_B: begin
                w_reg <= wt;
                if (!(val_t'(tl_reg[ci]) + wt >= mid_reg)) begin
                    tl_reg[ci] <= LOAD_W'(val_t'(tl_reg[ci]) + wt);
                end
            end
            S_BW_B2: begin
                tl_reg[cm1] <= LOAD_W'(val_t'(tl_reg[cm1]) - w_reg);
                ts_reg[ci]  <= s_reg - 1'b1;
            end
            default: ;
        endcase
    end

    // Report stage: one transfer per core slot, empty slots point past the row.
    logic            in_range;
    logic [IW-1:0]   out_start;
    load_t           out_load;

    assign in_range  = c_reg < n_reg;
    assign out_start = !in_range ? tot_reg : (pick_reg ? ts_reg[ci] : es_reg[ci]);
    assign out_load  = !in_range ? '0 : (pick_reg ? tl_reg[ci] : el_reg[ci]);

    assign s_tready = (state_reg == S_LOAD);
    assign m_tvalid = (state_reg == S_OUT);
    assign m_tlast  = (int'(c_reg) == MAX_CORES - 1);
    assign m_tdata  = {2'b00, out_load[LOAD_OUT_W-1:0], ITEMS_W'(out_start), SLOT_W'(c_reg)};

    `CWP_ASSERT_IMP(a_sides_exclusive, s_tready, !m_tvalid)
    `CWP_ASSERT_NXT(a_final_stalls_input, s_tvalid && s_tready && s_tlast, !s_tready)
    `CWP_ASSERT_NXT(a_report_end_reloads, m_tvalid && m_tready && m_tlast, s_tready)
    `CWP_ASSERT_IMP(a_div_only_in_wait, div_stat.busy, state_reg == S_DIVW)

endmodule
